[hdl/obb_pkg.sv]
`timescale 1ns / 1ps
// obb_pkg: widths, types, state codes and small helpers for the oriented box overlap unit
// no dependencies
package obb_pkg;

  localparam int COORD_W   = 32;
  localparam int EPS_W     = 16;
  localparam int FRAC_BITS = 16;
  localparam int WIDE_W    = 208;
  localparam int CNT_W     = 7;

  // multiplier bits scanned per operand class
  localparam logic [CNT_W-1:0] N_EPS  = CNT_W'(17);
  localparam logic [CNT_W-1:0] N_ROW  = CNT_W'(34);
  localparam logic [CNT_W-1:0] N_AXIS = CNT_W'(68);
  localparam logic [CNT_W-1:0] N_GAP  = CNT_W'(104);
  localparam logic [CNT_W-1:0] N_E4   = CNT_W'(36);

  localparam logic [3:0] LAST_AXIS  = 4'd14;
  localparam logic [3:0] FIRST_CROSS = 4'd6;
  localparam logic [2:0] LAST_TERM  = 3'd5;
  localparam logic [2:0] T0_ROW     = 3'd3;
  localparam logic [2:0] T1_ROW     = 3'd7;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [2:0][COORD_W-1:0] row_t;

  typedef enum logic [21:0] {
    S_IDLE = 22'd1 << 0,
    S_MUL  = 22'd1 << 1,
    S_E2D  = 22'd1 << 2,
    S_FW   = 22'd1 << 3,
    S_DL0  = 22'd1 << 4,
    S_DL1  = 22'd1 << 5,
    S_AX   = 22'd1 << 6,
    S_FACE = 22'd1 << 7,
    S_CA   = 22'd1 << 8,
    S_CB   = 22'd1 << 9,
    S_CK   = 22'd1 << 10,
    S_CN   = 22'd1 << 11,
    S_LN   = 22'd1 << 12,
    S_LNX  = 22'd1 << 13,
    S_T0   = 22'd1 << 14,
    S_T0X  = 22'd1 << 15,
    S_TR   = 22'd1 << 16,
    S_TRX  = 22'd1 << 17,
    S_CHK  = 22'd1 << 18,
    S_SQ   = 22'd1 << 19,
    S_CMP  = 22'd1 << 20,
    S_NEXT = 22'd1 << 21
  } state_t;

  function automatic wide_t sx32(input logic [COORD_W-1:0] v);
    return {{(WIDE_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic wide_t sx33(input logic [COORD_W:0] v);
    return {{(WIDE_W-COORD_W-1){v[COORD_W]}}, v};
  endfunction

  function automatic logic [1:0] nxt3(input logic [1:0] k);
    return (k == 2'd2) ? 2'd0 : k + 2'd1;
  endfunction

  function automatic logic [1:0] prv3(input logic [1:0] k);
    return (k == 2'd0) ? 2'd2 : k - 2'd1;
  endfunction

  function automatic wide_t wabs(input wide_t v);
    return v[WIDE_W-1] ? -v : v;
  endfunction

endpackage

[hdl/obb_overlap_test_3d_unit.sv]
`timescale 1ns / 1ps
// obb_overlap_test_3d_unit: separating-axis overlap test of two oriented boxes
// depends on obb_pkg
//
// a row transfer that is not row 3 of box 1 leaves busy low.
// row 3 of box 1 starts the test and busy stays high until done; the test ends early when an axis
// separates, and a cross axis whose length is too small is skipped.
// all products go through the shared bit-serial multiply-accumulate unit, one multiplier bit a cycle.
// done pulses for one cycle with overlap; the receiver cannot stall.
// rst (synchronous) returns to idle with sep_epsilon = 7; stored rows are undefined until written.
module obb_overlap_test_3d_unit
  import obb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      box_sel,
  input  logic [1:0]                row_idx,
  input  logic signed [COORD_W-1:0] row_x,
  input  logic signed [COORD_W-1:0] row_y,
  input  logic signed [COORD_W-1:0] row_z,
  input  logic                      cfg_we,
  input  logic [EPS_W-1:0]          cfg_wdata,
  output logic                      done,
  output logic                      overlap
);

  row_t mem [8];
  row_t rd;
  row_t hold;
  logic [2:0] raddr;

  state_t state;
  state_t ret;
  state_t fw_ret;

  logic [EPS_W-1:0] sep_epsilon;
  wide_t acc, mcand, mplier, gap, len2, sq, e2;
  wide_t nv [3];
  logic signed [COORD_W:0] dl [3];
  logic [CNT_W-1:0] cnt;
  logic [3:0] ax;
  logic [1:0] ci, cj, k;
  logic [2:0] t;
  logic [2:0] t_inc;
  logic h;

  logic accept;
  wide_t addend, flim, llim, e4;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign addend = mplier[0] ? mcand : '0;
  assign flim   = wide_t'(sep_epsilon) <<< (FRAC_BITS + 1);
  assign llim   = e2 <<< (2 * FRAC_BITS);
  assign e4     = e2 <<< 2;
  assign t_inc  = t + 3'd1;

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[{box_sel, row_idx}] <= {row_z, row_y, row_x};
    end
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_epsilon <= EPS_W'(7);
    end else if (cfg_we) begin
      sep_epsilon <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && box_sel && row_idx == 2'd3) begin
            acc    <= '0;
            mcand  <= wide_t'(sep_epsilon);
            mplier <= wide_t'(sep_epsilon);
            cnt    <= N_EPS;
            ret    <= S_E2D;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          // top scanned bit carries negative weight
          acc    <= (cnt == CNT_W'(1)) ? acc - addend : acc + addend;
          mcand  <= mcand <<< 1;
          mplier <= mplier >>> 1;
          cnt    <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= ret;
          end
        end
        S_E2D: begin
          e2     <= acc;
          raddr  <= T0_ROW;
          fw_ret <= S_DL0;
          state  <= S_FW;
        end
        S_FW: begin
          state <= fw_ret;
        end
        S_DL0: begin
          for (int i = 0; i < 3; i++) begin
            dl[i] <= {rd[i][COORD_W-1], rd[i]};
          end
          raddr  <= T1_ROW;
          fw_ret <= S_DL1;
          state  <= S_FW;
        end
        S_DL1: begin
          for (int i = 0; i < 3; i++) begin
            dl[i] <= dl[i] - {rd[i][COORD_W-1], rd[i]};
          end
          ax    <= '0;
          ci    <= '0;
          cj    <= '0;
          state <= S_AX;
        end
        S_AX: begin
          if (ax < FIRST_CROSS) begin
            raddr  <= {ax[0], ax[2:1]};
            fw_ret <= S_FACE;
          end else begin
            raddr  <= {1'b0, ci};
            fw_ret <= S_CA;
          end
          state <= S_FW;
        end
        S_FACE: begin
          for (int i = 0; i < 3; i++) begin
            nv[i] <= sx32(rd[i]);
          end
          k     <= '0;
          state <= S_T0;
        end
        S_CA: begin
          hold   <= rd;
          raddr  <= {1'b1, cj};
          fw_ret <= S_CB;
          state  <= S_FW;
        end
        S_CB: begin
          k     <= '0;
          h     <= 1'b0;
          state <= S_CK;
        end
        S_CK: begin
          // cross product component k in two signed products
          if (!h) begin
            acc    <= '0;
            mplier <= sx32(hold[nxt3(k)]);
            mcand  <= sx32(rd[prv3(k)]);
          end else begin
            mplier <= sx32(hold[prv3(k)]);
            mcand  <= -sx32(rd[nxt3(k)]);
          end
          cnt   <= N_ROW;
          ret   <= S_CN;
          state <= S_MUL;
        end
        S_CN: begin
          if (!h) begin
            h     <= 1'b1;
            state <= S_CK;
          end else begin
            nv[k] <= acc;
            h     <= 1'b0;
            if (k == 2'd2) begin
              k     <= '0;
              state <= S_LN;
            end else begin
              k     <= k + 2'd1;
              state <= S_CK;
            end
          end
        end
        S_LN: begin
          acc    <= (k == 2'd0) ? '0 : acc;
          mcand  <= nv[k];
          mplier <= nv[k];
          cnt    <= N_AXIS;
          ret    <= S_LNX;
          state  <= S_MUL;
        end
        S_LNX: begin
          if (k == 2'd2) begin
            len2  <= acc;
            k     <= '0;
            state <= (acc > llim) ? S_T0 : S_NEXT;
          end else begin
            k     <= k + 2'd1;
            state <= S_LN;
          end
        end
        S_T0: begin
          acc    <= (k == 2'd0) ? '0 : acc;
          mcand  <= nv[k];
          mplier <= sx33(dl[k]);
          cnt    <= N_ROW;
          ret    <= S_T0X;
          state  <= S_MUL;
        end
        S_T0X: begin
          if (k == 2'd2) begin
            gap    <= wabs(acc) <<< 1;
            k      <= '0;
            t      <= '0;
            raddr  <= 3'd0;
            fw_ret <= S_TR;
            state  <= S_FW;
          end else begin
            k     <= k + 2'd1;
            state <= S_T0;
          end
        end
        S_TR: begin
          acc    <= (k == 2'd0) ? '0 : acc;
          mcand  <= nv[k];
          mplier <= sx32(rd[k]);
          cnt    <= N_ROW;
          ret    <= S_TRX;
          state  <= S_MUL;
        end
        S_TRX: begin
          if (k == 2'd2) begin
            gap <= gap - wabs(acc);
            k   <= '0;
            if (t == LAST_TERM) begin
              state <= S_CHK;
            end else begin
              t      <= t_inc;
              raddr  <= {t_inc[0], t_inc[2:1]};
              fw_ret <= S_TR;
              state  <= S_FW;
            end
          end else begin
            k     <= k + 2'd1;
            state <= S_TR;
          end
        end
        S_CHK: begin
          if (ax < FIRST_CROSS) begin
            if (gap > flim) begin
              done    <= 1'b1;
              overlap <= 1'b0;
              state   <= S_IDLE;
            end else begin
              state <= S_NEXT;
            end
          end else if (gap[WIDE_W-1] || gap == '0) begin
            state <= S_NEXT;
          end else begin
            acc    <= '0;
            mcand  <= gap;
            mplier <= gap;
            cnt    <= N_GAP;
            ret    <= S_SQ;
            state  <= S_MUL;
          end
        end
        S_SQ: begin
          // compare squares so the cross axis needs no normalising
          sq     <= acc;
          acc    <= '0;
          mcand  <= len2;
          mplier <= e4;
          cnt    <= N_E4;
          ret    <= S_CMP;
          state  <= S_MUL;
        end
        S_CMP: begin
          if (sq > acc) begin
            done    <= 1'b1;
            overlap <= 1'b0;
            state   <= S_IDLE;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (ax == LAST_AXIS) begin
            done    <= 1'b1;
            overlap <= 1'b1;
            state   <= S_IDLE;
          end else begin
            ax <= ax + 4'd1;
            if (ax >= FIRST_CROSS) begin
              if (cj == 2'd2) begin
                cj <= '0;
                ci <= ci + 2'd1;
              end else begin
                cj <= cj + 2'd1;
              end
            end
            state <= S_AX;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a running test");

  a_last_row_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && box_sel && row_idx == 2'd3) |=> busy)
    else $error("last row transfer did not start the test");

  a_other_row_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && !(box_sel && row_idx == 2'd3)) |=> (!busy && !done))
    else $error("row transfer other than the last produced activity");

  a_single_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

[test/tb_obb_overlap_test_3d_unit.sv]
`timescale 1ns / 1ps
// tb_obb_overlap_test_3d_unit: self-checking bench for the oriented box overlap unit
// depends on obb_pkg and obb_overlap_test_3d_unit; exact integer predictor, queue-fed driver
module tb_obb_overlap_test_3d_unit;
  import obb_pkg::*;

  typedef logic signed [255:0] big_t;
  typedef enum logic [1:0] {K_ROW, K_CFG, K_DRAIN} kind_t;
  typedef struct {
    kind_t       kind;
    logic        box;
    logic [1:0]  row;
    logic [31:0] x, y, z;
  } stim_t;

  logic clk;
  logic rst;
  logic start = 1'b0;
  logic busy;
  logic box_sel = 1'b0;
  logic cfg_we = 1'b0;
  logic done, overlap;
  logic [1:0] row_idx = 2'd0;
  logic signed [COORD_W-1:0] row_x = '0;
  logic signed [COORD_W-1:0] row_y = '0;
  logic signed [COORD_W-1:0] row_z = '0;
  logic [EPS_W-1:0] cfg_wdata = '0;

  obb_overlap_test_3d_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .box_sel(box_sel),
    .row_idx(row_idx), .row_x(row_x), .row_y(row_y), .row_z(row_z),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .overlap(overlap)
  );

  localparam int WATCHDOG = 60000;

  stim_t pending_rows[$];
  logic  overlap_due[$];
  logic signed [31:0] box_rows[2][4][3];
  logic [15:0] eps_model;
  big_t ax0[3][3], ax1[3][3], dl[3];
  int acc_cnt = 0;
  int acc_seen = 0;
  int issued = 0;
  int errors = 0;
  int stalled = 0;
  int quiet = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic big_t babs(input big_t v);
    return v < 0 ? -v : v;
  endfunction

  function automatic big_t proj(input big_t ax, ay, az, nx, ny, nz);
    return ax * nx + ay * ny + az * nz;
  endfunction

  // twice the gap of the two intervals on axis n, scaled by n
  function automatic big_t gap2(input big_t nx, ny, nz);
    big_t g;
    g = babs(proj(dl[0], dl[1], dl[2], nx, ny, nz));
    g = g + g;
    for (int i = 0; i < 3; i++) begin
      g = g - babs(proj(ax0[i][0], ax0[i][1], ax0[i][2], nx, ny, nz));
      g = g - babs(proj(ax1[i][0], ax1[i][1], ax1[i][2], nx, ny, nz));
    end
    return g;
  endfunction

  function automatic logic boxes_overlap();
    big_t e, face_lim, len_lim, four_e2, cx, cy, cz, len2, g;
    e = big_t'(eps_model);
    face_lim = e <<< (FRAC_BITS + 1);
    len_lim = (e * e) <<< (2 * FRAC_BITS);
    four_e2 = e * e * 4;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        ax0[i][k] = box_rows[0][i][k];
        ax1[i][k] = box_rows[1][i][k];
      end
      dl[i] = big_t'(box_rows[0][3][i]) - big_t'(box_rows[1][3][i]);
    end
    for (int i = 0; i < 3; i++) begin
      if (gap2(ax0[i][0], ax0[i][1], ax0[i][2]) > face_lim) return 1'b0;
      if (gap2(ax1[i][0], ax1[i][1], ax1[i][2]) > face_lim) return 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cx = ax0[i][1] * ax1[j][2] - ax0[i][2] * ax1[j][1];
        cy = ax0[i][2] * ax1[j][0] - ax0[i][0] * ax1[j][2];
        cz = ax0[i][0] * ax1[j][1] - ax0[i][1] * ax1[j][0];
        len2 = cx * cx + cy * cy + cz * cz;
        if (len2 > len_lim) begin
          g = gap2(cx, cy, cz);
          if (g > 0 && g * g > four_e2 * len2) return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  // driver: one change per signal per falling edge
  always @(negedge clk) begin
    logic nstart, nwe;
    stim_t it;
    int idle_pct;
    nstart = 1'b0;
    nwe = 1'b0;
    if (!rst) begin
      if (start && acc_cnt == acc_seen) begin
        nstart = 1'b1;
      end else if (pending_rows.size() > 0) begin
        it = pending_rows[0];
        idle_pct = issued < 533 ? 29 : (issued < 1066 ? 63 : 0);
        if (it.kind != K_ROW) begin
          if (overlap_due.size() == 0 && !busy) quiet++;
          else quiet = 0;
          if (quiet >= 8) begin
            if (it.kind == K_CFG) begin
              nwe = 1'b1;
              cfg_wdata <= it.x[15:0];
            end
            void'(pending_rows.pop_front());
            quiet = 0;
          end
        end else if ($urandom_range(99) >= idle_pct) begin
          nstart = 1'b1;
          box_sel <= it.box;
          row_idx <= it.row;
          row_x <= it.x;
          row_y <= it.y;
          row_z <= it.z;
          void'(pending_rows.pop_front());
          issued++;
        end
      end
    end
    acc_seen = acc_cnt;
    start <= nstart;
    cfg_we <= nwe;
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    logic active;
    logic want;
    active = 1'b0;
    if (rst) begin
      eps_model = 16'd7;
    end else begin
      if (cfg_we) begin
        eps_model = cfg_wdata;
        active = 1'b1;
      end
      if (done) begin
        active = 1'b1;
        if (overlap_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual overlap=%0b", $time, overlap);
          errors++;
        end else begin
          want = overlap_due.pop_front();
          if (overlap !== want) begin
            $display("%0t: overlap mismatch, expected %0b, actual %0b", $time, want, overlap);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        acc_cnt++;
        active = 1'b1;
        box_rows[box_sel][row_idx][0] = row_x;
        box_rows[box_sel][row_idx][1] = row_y;
        box_rows[box_sel][row_idx][2] = row_z;
        if (box_sel && row_idx == 2'd3) begin
          overlap_due.insert(overlap_due.size(), boxes_overlap());
        end
      end
      stalled = active ? 0 : stalled + 1;
      if (stalled >= WATCHDOG) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic add_row(input logic b, input logic [1:0] r, input logic [31:0] x, y, z);
    stim_t it;
    it.kind = K_ROW; it.box = b; it.row = r; it.x = x; it.y = y; it.z = z;
    pending_rows.insert(pending_rows.size(), it);
  endtask

  task automatic add_ctrl(input kind_t k, input logic [15:0] v);
    stim_t it;
    it.kind = k; it.box = 1'b0; it.row = 2'd0; it.x = 32'(v); it.y = '0; it.z = '0;
    pending_rows.insert(pending_rows.size(), it);
  endtask

  function automatic logic [31:0] rand_coord(input bit near);
    case ($urandom_range(9))
      0: return $urandom;
      1: case ($urandom_range(3))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return 32'h0;
           default: return 32'hffff_ffff;
         endcase
      2: return $urandom_range(200) - 100;
      default: return near ? $urandom_range(32'h40000) - 32'h20000
                           : $urandom_range(32'h20000) - 32'h10000;
    endcase
  endfunction

  // full set of both boxes; axes are unit axes scaled, centres a given offset apart
  task automatic add_pair(input logic [31:0] s0, s1, off, input logic zero_axis);
    add_row(1'b0, 2'd0, s0, 32'h0, 32'h0);
    add_row(1'b0, 2'd1, 32'h0, zero_axis ? 32'h0 : s0, 32'h0);
    add_row(1'b0, 2'd2, 32'h0, 32'h0, s0);
    add_row(1'b0, 2'd3, 32'h0, 32'h0, 32'h0);
    add_row(1'b1, 2'd0, s1, 32'h0, 32'h0);
    add_row(1'b1, 2'd1, 32'h0, s1, 32'h0);
    add_row(1'b1, 2'd2, 32'h0, 32'h0, s1);
    add_row(1'b1, 2'd3, off, 32'h0, 32'h0);
  endtask

  initial begin
    int sets;
    rst = 1'b1;

    // directed: touching, overlapping, separated, degenerate face, extremes
    add_pair(32'h10000, 32'h10000, 32'h10000, 1'b0);
    add_pair(32'h10000, 32'h10000, 32'h10008, 1'b0);
    add_pair(32'h10000, 32'h20000, 32'h8000, 1'b1);
    add_ctrl(K_CFG, 16'd0);
    add_row(1'b1, 2'd3, 32'h10001, 32'h0, 32'h0);
    add_row(1'b0, 2'd0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    add_row(1'b1, 2'd1, 32'h7fff_ffff, 32'h8000_0000, 32'h1);
    add_row(1'b1, 2'd3, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
    add_ctrl(K_CFG, 16'hffff);
    add_pair(32'h10000, 32'h10000, 32'h1ffff, 1'b0);
    add_row(1'b1, 2'd3, 32'h20001, 32'h0, 32'h0);
    add_ctrl(K_CFG, 16'd7);

    sets = 0;
    while (pending_rows.size() < 1600) begin
      sets++;
      if (sets % 40 == 0) add_ctrl(K_CFG, $urandom_range(3) == 0 ? 16'hffff : 16'($urandom));
      if (sets % 40 == 20) begin
        add_ctrl(K_CFG, $urandom_range(3) == 0 ? 16'd0 : 16'($urandom_range(64)));
      end
      if (sets == 60) add_ctrl(K_DRAIN, 16'd0);
      if ($urandom_range(9) < 7) begin
        // well-formed set: seven rows in order, then the closing row last
        for (int k = 0; k < 7; k++) begin
          logic b;
          logic [1:0] r;
          b = (k < 4) ? 1'b0 : 1'b1;
          r = (k < 4) ? 2'(k) : 2'(k - 4);
          add_row(b, r, rand_coord(r != 2'd3), rand_coord(r != 2'd3), rand_coord(r != 2'd3));
        end
        add_row(1'b1, 2'd3, rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0));
      end else begin
        // noise: loose rows, sometimes closing with row 3 of box 1
        repeat ($urandom_range(1, 4)) begin
          logic b;
          logic [1:0] r;
          b = 1'($urandom_range(1));
          r = 2'($urandom_range(b ? 2 : 3));
          add_row(b, r, rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0));
        end
        if ($urandom_range(1)) begin
          add_row(1'b1, 2'd3, rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0));
        end
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (pending_rows.size() == 0);
    @(posedge clk);
    wait (!start && overlap_due.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
